// ===== design/npp_pkg.sv =====
// npp_pkg: shared types and constants of the nmea position parser
`default_nettype none

package npp_pkg;

  localparam int FRAC_DIGITS = 5;
  localparam int HDR_LEN     = 6;
  localparam int POS_W       = 3;
  localparam int FIELD_W     = 4;
  localparam int FIELD_MAX   = 15;
  localparam int LAT_FIELD_GGA = 2;
  localparam int LAT_FIELD_RMC = 3;
  localparam int NEED_GGA    = 6;
  localparam int NEED_RMC    = 7;
  localparam int COUNT_W     = FIELD_W + 1;

  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] CHAR_0      = 8'h30;
  localparam logic [7:0] CHAR_9      = 8'h39;
  localparam logic [7:0] CHAR_A      = 8'h41;
  localparam logic [7:0] CHAR_C      = 8'h43;
  localparam logic [7:0] CHAR_G      = 8'h47;
  localparam logic [7:0] CHAR_M      = 8'h4D;
  localparam logic [7:0] CHAR_N      = 8'h4E;
  localparam logic [7:0] CHAR_P      = 8'h50;
  localparam logic [7:0] CHAR_R      = 8'h52;
  localparam logic [7:0] CHAR_S      = 8'h53;
  localparam logic [7:0] CHAR_W      = 8'h57;

  function automatic longint pow10(int n);
    longint p;
    p = 1;
    for (int i = 0; i < n; i++) p = p * 10;
    return p;
  endfunction

  function automatic longint gcd_sub(longint a, longint b);
    longint x;
    longint y;
    x = a;
    y = b;
    while (x != y) begin
      if (x > y) x = x - y;
      else y = y - x;
    end
    return x;
  endfunction

  localparam longint SCALE     = pow10(FRAC_DIGITS);
  localparam longint UNITS     = 10000000;
  localparam longint MIN_DEN   = 60 * SCALE;
  localparam longint GCD_UM    = gcd_sub(UNITS, MIN_DEN);
  localparam longint NUM_K     = UNITS / GCD_UM;
  localparam longint DEN       = MIN_DEN / GCD_UM;

  localparam int     WHOLE_W   = 17;
  localparam longint WHOLE_MAX = 131071;
  localparam int     FRAC_W    = $clog2(SCALE);
  localparam int     FD_W      = $clog2(FRAC_DIGITS + 1);

  localparam int     DIV100_S  = WHOLE_W + $clog2(100);
  localparam longint DIV100_M  = ((longint'(1) << DIV100_S) + 99) / 100;
  localparam int     DIV100_MW = $clog2(DIV100_M + 1);
  localparam longint DEG_MAX   = WHOLE_MAX / 100;
  localparam int     DEG_W     = $clog2(DEG_MAX + 1);
  localparam int     MM_W      = $clog2(100);

  localparam longint C_MM      = SCALE * NUM_K;
  localparam int     NUM_W     = $clog2(100 * SCALE * NUM_K);
  localparam int     REC_S     = NUM_W + $clog2(DEN);
  localparam longint REC_M     = ((longint'(1) << REC_S) + DEN - 1) / DEN;
  localparam int     REC_MW    = $clog2(REC_M + 1);
  localparam int     Q_W       = $clog2(100 * SCALE * NUM_K / DEN + 1);

  localparam int     DEGU_W    = $clog2(DEG_MAX * UNITS + 1);
  localparam int     SUM_W     = DEGU_W + 1;
  localparam longint MAG_MAX   = 1800000000;
  localparam int     MAG_W     = 31;
  localparam int     COORD_W   = 32;

  localparam int     CONV_STAGES = 5;

  typedef enum logic [1:0] {
    ST_PARSED      = 2'd0,
    ST_UNSUPPORTED = 2'd1,
    ST_FEW_FIELDS  = 2'd2
  } status_e;

  typedef struct packed {
    logic [WHOLE_W-1:0] whole;
    logic [FRAC_W-1:0]  frac;
    logic [FD_W-1:0]    fd;
    logic               point;
    logic               ended;
  } num_t;

  typedef struct packed {
    logic [WHOLE_W-1:0] whole;
    logic [FRAC_W-1:0]  frac;
    logic [FD_W-1:0]    fd;
    logic               neg;
  } coord_t;

  typedef struct packed {
    status_e status;
    logic    kind;
  } meta_t;

  typedef struct packed {
    meta_t  meta;
    coord_t lat;
    coord_t lon;
  } line_t;

endpackage

`default_nettype wire

// ===== design/npp_parser.sv =====
// npp_parser: byte-wise sentence parser with line-end snapshot register
`default_nettype none

module npp_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                byte_valid_i,
  input  logic [7:0]          byte_i,
  input  logic                load_i,
  output logic                line_valid_o,
  output npp_pkg::line_t      line_o
);

  function automatic npp_pkg::num_t feed(npp_pkg::num_t n, logic [7:0] b);
    npp_pkg::num_t r;
    logic [3:0] d;
    logic [npp_pkg::WHOLE_W+3:0] w;
    logic [npp_pkg::FRAC_W+3:0] f;
    r = n;
    d = 4'(b - npp_pkg::CHAR_0);
    w = (npp_pkg::WHOLE_W+4)'(n.whole) * (npp_pkg::WHOLE_W+4)'(10)
        + (npp_pkg::WHOLE_W+4)'(d);
    f = (npp_pkg::FRAC_W+4)'(n.frac) * (npp_pkg::FRAC_W+4)'(10)
        + (npp_pkg::FRAC_W+4)'(d);
    if (!n.ended) begin
      if (b >= npp_pkg::CHAR_0 && b <= npp_pkg::CHAR_9) begin
        if (!n.point) begin
          if (w > (npp_pkg::WHOLE_W+4)'(npp_pkg::WHOLE_MAX)) begin
            r.whole = npp_pkg::WHOLE_W'(npp_pkg::WHOLE_MAX);
          end else begin
            r.whole = w[npp_pkg::WHOLE_W-1:0];
          end
        end else if (n.fd < npp_pkg::FD_W'(npp_pkg::FRAC_DIGITS)) begin
          r.frac = f[npp_pkg::FRAC_W-1:0];
          r.fd   = n.fd + 1'b1;
        end
      end else if (b == npp_pkg::CHAR_DOT && !n.point) begin
        r.point = 1'b1;
      end else begin
        r.ended = 1'b1;
      end
    end
    return r;
  endfunction

  logic [npp_pkg::POS_W-1:0]   pos_q, pos_d;
  logic                        hdr_q, hdr_d;
  logic                        rmc_q, rmc_d;
  logic [npp_pkg::FIELD_W-1:0] field_q, field_d;
  logic                        seg_q, seg_d;
  npp_pkg::num_t               lat_q, lat_d;
  npp_pkg::num_t               lon_q, lon_d;
  logic                        lat_neg_q, lat_neg_d;
  logic                        lon_neg_q, lon_neg_d;
  logic                        line_valid_q, line_valid_d;
  npp_pkg::line_t              line_q, line_d;

  logic                        is_eol;
  logic                        ok;
  logic [npp_pkg::COUNT_W-1:0] count;
  logic [npp_pkg::COUNT_W-1:0] need;
  npp_pkg::status_e            status;
  logic [npp_pkg::FIELD_W-1:0] base;
  logic                        is_dir;
  npp_pkg::line_t              snap;

  always_comb begin
    is_eol = (byte_i == npp_pkg::CHAR_CR) || (byte_i == npp_pkg::CHAR_LF);
    is_dir = (byte_i == npp_pkg::CHAR_S) || (byte_i == npp_pkg::CHAR_W);
    count  = npp_pkg::COUNT_W'(field_q) + npp_pkg::COUNT_W'(seg_q);
    need   = rmc_q ? npp_pkg::COUNT_W'(npp_pkg::NEED_RMC)
                   : npp_pkg::COUNT_W'(npp_pkg::NEED_GGA);
    priority if (!hdr_q || pos_q < npp_pkg::POS_W'(npp_pkg::HDR_LEN)) begin
      status = npp_pkg::ST_UNSUPPORTED;
    end else if (count < need) begin
      status = npp_pkg::ST_FEW_FIELDS;
    end else begin
      status = npp_pkg::ST_PARSED;
    end

    snap = '0;
    snap.meta.status = status;
    if (status == npp_pkg::ST_PARSED) begin
      snap.meta.kind = rmc_q;
      snap.lat = '{whole: lat_q.whole, frac: lat_q.frac, fd: lat_q.fd, neg: lat_neg_q};
      snap.lon = '{whole: lon_q.whole, frac: lon_q.frac, fd: lon_q.fd, neg: lon_neg_q};
    end
  end

  always_comb begin
    pos_d     = pos_q;
    hdr_d     = hdr_q;
    rmc_d     = rmc_q;
    field_d   = field_q;
    seg_d     = seg_q;
    lat_d     = lat_q;
    lon_d     = lon_q;
    lat_neg_d = lat_neg_q;
    lon_neg_d = lon_neg_q;
    ok        = 1'b1;
    base      = npp_pkg::FIELD_W'(npp_pkg::LAT_FIELD_GGA);
    if (byte_valid_i) begin
      if (is_eol) begin
        pos_d     = '0;
        hdr_d     = 1'b1;
        rmc_d     = 1'b0;
        field_d   = '0;
        seg_d     = 1'b0;
        lat_d     = '0;
        lon_d     = '0;
        lat_neg_d = 1'b0;
        lon_neg_d = 1'b0;
      end else begin
        if (pos_q < npp_pkg::POS_W'(npp_pkg::HDR_LEN)) begin
          unique case (pos_q)
            3'd0: ok = (byte_i == npp_pkg::CHAR_DOLLAR);
            3'd1: ok = (byte_i == npp_pkg::CHAR_G);
            3'd2: ok = (byte_i == npp_pkg::CHAR_P) || (byte_i == npp_pkg::CHAR_N);
            3'd3: begin
              ok = (byte_i == npp_pkg::CHAR_G) || (byte_i == npp_pkg::CHAR_R);
              if (byte_i == npp_pkg::CHAR_R) rmc_d = 1'b1;
            end
            3'd4: ok = (byte_i == (rmc_q ? npp_pkg::CHAR_M : npp_pkg::CHAR_G));
            default: ok = (byte_i == (rmc_q ? npp_pkg::CHAR_C : npp_pkg::CHAR_A));
          endcase
          if (!ok) hdr_d = 1'b0;
          pos_d = pos_q + 1'b1;
        end
        if (byte_i == npp_pkg::CHAR_COMMA) begin
          if (field_q != npp_pkg::FIELD_W'(npp_pkg::FIELD_MAX)) field_d = field_q + 1'b1;
          seg_d = 1'b0;
        end else begin
          base = rmc_d ? npp_pkg::FIELD_W'(npp_pkg::LAT_FIELD_RMC)
                       : npp_pkg::FIELD_W'(npp_pkg::LAT_FIELD_GGA);
          priority if (field_q == base) begin
            lat_d = feed(lat_q, byte_i);
          end else if (field_q == npp_pkg::FIELD_W'(base + 1)) begin
            if (!seg_q) lat_neg_d = is_dir;
          end else if (field_q == npp_pkg::FIELD_W'(base + 2)) begin
            lon_d = feed(lon_q, byte_i);
          end else if (field_q == npp_pkg::FIELD_W'(base + 3)) begin
            if (!seg_q) lon_neg_d = is_dir;
          end else begin
          end
          seg_d = 1'b1;
        end
      end
    end
  end

  always_comb begin
    line_valid_d = line_valid_q;
    line_d       = line_q;
    if (load_i) begin
      line_valid_d = byte_valid_i && is_eol && (pos_q != '0);
      line_d       = snap;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      hdr_q        <= 1'b1;
      rmc_q        <= 1'b0;
      field_q      <= '0;
      seg_q        <= 1'b0;
      lat_q        <= '0;
      lon_q        <= '0;
      lat_neg_q    <= 1'b0;
      lon_neg_q    <= 1'b0;
      line_valid_q <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      hdr_q        <= hdr_d;
      rmc_q        <= rmc_d;
      field_q      <= field_d;
      seg_q        <= seg_d;
      lat_q        <= lat_d;
      lon_q        <= lon_d;
      lat_neg_q    <= lat_neg_d;
      lon_neg_q    <= lon_neg_d;
      line_valid_q <= line_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    line_q <= line_d;
  end

  assign line_valid_o = line_valid_q;
  assign line_o       = line_q;

endmodule

`default_nettype wire

// ===== design/npp_conv.sv =====
// npp_conv: pipelined ddmm.mmmmm to signed 1e-7 degree conversion
`default_nettype none

module npp_conv (
  input  logic                                  clk_i,
  input  logic [npp_pkg::CONV_STAGES-1:0]       en_i,
  input  npp_pkg::coord_t                       coord_i,
  output logic signed [npp_pkg::COORD_W-1:0]    coord_o
);

  localparam int DPW = npp_pkg::WHOLE_W + npp_pkg::DIV100_MW;
  localparam int FPW = 2 * npp_pkg::FRAC_W;
  localparam int RPW = npp_pkg::NUM_W + npp_pkg::REC_MW;

  // ten to the power of the missing fraction digits
  function automatic logic [npp_pkg::FRAC_W-1:0] frac_scale(logic [npp_pkg::FD_W-1:0] fd);
    logic [npp_pkg::FRAC_W-1:0] p;
    p = npp_pkg::FRAC_W'(1);
    for (int i = 0; i < npp_pkg::FRAC_DIGITS; i++) begin
      if (npp_pkg::FD_W'(i) >= fd) p = npp_pkg::FRAC_W'(p * npp_pkg::FRAC_W'(10));
    end
    return p;
  endfunction

  logic [npp_pkg::WHOLE_W-1:0] whole1_q;
  logic [npp_pkg::DEG_W-1:0]   deg1_q, deg1_d;
  logic [npp_pkg::FRAC_W-1:0]  fsc1_q, fsc1_d;
  logic                        neg1_q;

  logic [npp_pkg::MM_W-1:0]    mm2_q, mm2_d;
  logic [npp_pkg::FRAC_W-1:0]  fsc2_q;
  logic [npp_pkg::DEGU_W-1:0]  degu2_q, degu2_d;
  logic                        neg2_q;

  logic [npp_pkg::NUM_W-1:0]   num3_q, num3_d;
  logic [npp_pkg::DEGU_W-1:0]  degu3_q;
  logic                        neg3_q;

  logic [npp_pkg::Q_W-1:0]     q4_q, q4_d;
  logic [npp_pkg::DEGU_W-1:0]  degu4_q;
  logic                        neg4_q;

  logic [npp_pkg::COORD_W-1:0] coord5_q, coord5_d;

  logic [DPW-1:0]                 deg_prod;
  logic [FPW-1:0]                 fsc_prod;
  logic [npp_pkg::WHOLE_W-1:0]    hund;
  logic [RPW-1:0]                 rec_prod;
  logic [npp_pkg::SUM_W-1:0]      sum;
  logic [npp_pkg::MAG_W-1:0]      mag;
  logic [npp_pkg::COORD_W-1:0]    mag_ext;

  always_comb begin
    // degrees by reciprocal multiply, minute fraction aligned to full digits
    deg_prod = DPW'(coord_i.whole) * DPW'(npp_pkg::DIV100_M);
    deg1_d   = deg_prod[npp_pkg::DIV100_S +: npp_pkg::DEG_W];
    fsc_prod = FPW'(coord_i.frac) * FPW'(frac_scale(coord_i.fd));
    fsc1_d   = fsc_prod[npp_pkg::FRAC_W-1:0];

    hund     = npp_pkg::WHOLE_W'(deg1_q) * npp_pkg::WHOLE_W'(100);
    mm2_d    = npp_pkg::MM_W'(whole1_q - hund);
    degu2_d  = npp_pkg::DEGU_W'(deg1_q) * npp_pkg::DEGU_W'(npp_pkg::UNITS);

    num3_d   = npp_pkg::NUM_W'(mm2_q) * npp_pkg::NUM_W'(npp_pkg::C_MM)
             + npp_pkg::NUM_W'(fsc2_q) * npp_pkg::NUM_W'(npp_pkg::NUM_K);

    rec_prod = RPW'(num3_q) * RPW'(npp_pkg::REC_M);
    q4_d     = rec_prod[npp_pkg::REC_S +: npp_pkg::Q_W];

    sum      = npp_pkg::SUM_W'(degu4_q) + npp_pkg::SUM_W'(q4_q);
    mag      = (sum > npp_pkg::SUM_W'(npp_pkg::MAG_MAX)) ? npp_pkg::MAG_W'(npp_pkg::MAG_MAX)
                                                         : sum[npp_pkg::MAG_W-1:0];
    mag_ext  = npp_pkg::COORD_W'(mag);
    coord5_d = neg4_q ? (npp_pkg::COORD_W'(0) - mag_ext) : mag_ext;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      whole1_q <= coord_i.whole;
      deg1_q   <= deg1_d;
      fsc1_q   <= fsc1_d;
      neg1_q   <= coord_i.neg;
    end
    if (en_i[1]) begin
      mm2_q   <= mm2_d;
      fsc2_q  <= fsc1_q;
      degu2_q <= degu2_d;
      neg2_q  <= neg1_q;
    end
    if (en_i[2]) begin
      num3_q  <= num3_d;
      degu3_q <= degu2_q;
      neg3_q  <= neg2_q;
    end
    if (en_i[3]) begin
      q4_q    <= q4_d;
      degu4_q <= degu3_q;
      neg4_q  <= neg3_q;
    end
    if (en_i[4]) begin
      coord5_q <= coord5_d;
    end
  end

  assign coord_o = $signed(coord5_q);

endmodule

`default_nettype wire

// ===== design/nmea_position_parser_core.sv =====
// nmea_position_parser_core: top level, stream ports and result pipeline control
// path: a status request leaves m_axis after the line-ending byte is taken, through
// one snapshot register, then five conversion stages
// throughput: one received byte per cycle while s_axis_tready is high; a stalled output holds the pipe and
// s_axis_tready falls only once every stage holds a result
// reset: asynchronous active low, clears the parser state and all stage valid bits
`default_nettype none

module nmea_position_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // latitude[31:0], longitude[63:32]
  output logic [2:0]  m_axis_tuser    // status[1:0], sentence_kind[2]
);

  localparam int NS = npp_pkg::CONV_STAGES;

  logic                 line_valid;
  npp_pkg::line_t       line;
  logic [NS+1:0]        rdy;
  logic [NS:0]          v_all;
  logic [NS:1]          v_q, v_d;
  npp_pkg::meta_t       meta_q [1:NS];
  logic signed [31:0]   lat, lon;
  logic                 accept;

  assign accept = s_axis_tvalid && s_axis_tready;

  npp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (accept),
    .byte_i       (s_axis_tdata),
    .load_i       (rdy[0]),
    .line_valid_o (line_valid),
    .line_o       (line)
  );

  npp_conv u_conv_lat (
    .clk_i   (clk_i),
    .en_i    (rdy[NS:1]),
    .coord_i (line.lat),
    .coord_o (lat)
  );

  npp_conv u_conv_lon (
    .clk_i   (clk_i),
    .en_i    (rdy[NS:1]),
    .coord_i (line.lon),
    .coord_o (lon)
  );

  always_comb begin
    v_all = {v_q, line_valid};
    rdy[NS+1] = m_axis_tready;
    for (int k = NS; k >= 0; k--) begin
      rdy[k] = !v_all[k] || rdy[k+1];
    end
    for (int k = 1; k <= NS; k++) begin
      v_d[k] = rdy[k] ? v_all[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) meta_q[1] <= line.meta;
    for (int k = 2; k <= NS; k++) begin
      if (rdy[k]) meta_q[k] <= meta_q[k-1];
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = v_q[NS];
  assign m_axis_tuser  = {meta_q[NS].kind, meta_q[NS].status};
  assign m_axis_tdata  = {lon, lat};

  // unparsed lines carry no kind and no coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[1:0] != npp_pkg::ST_PARSED)
    |-> (m_axis_tdata == 64'd0) && !m_axis_tuser[2])
    else $error("unparsed status with nonzero payload");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[31:0]) <= 32'sd1800000000)
                   && ($signed(m_axis_tdata[31:0]) >= -32'sd1800000000)
                   && ($signed(m_axis_tdata[63:32]) <= 32'sd1800000000)
                   && ($signed(m_axis_tdata[63:32]) >= -32'sd1800000000))
    else $error("coordinate outside saturation range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&v_all) && !m_axis_tready |-> !s_axis_tready)
    else $error("input ready while pipe is full and stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NS] && !m_axis_tready
    |=> v_q[NS] && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output request moved during output stall");

endmodule

`default_nettype wire
